### design/pbc_pkg.sv
// shared types and constants for the pixel blit compositor
package pbc_pkg;

	localparam int PALETTE_DEPTH = 256;
	localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

	localparam logic [31:0] OPAQUE_ALPHA = 32'hFF00_0000;
	localparam logic [7:0] CH_MAX = 8'hFF;

	typedef enum logic [1:0] {
		MODE_PALETTE = 2'd0,
		MODE_ALPHA   = 2'd1,
		MODE_COPY    = 2'd2
	} pbc_mode_t;

	typedef enum logic [1:0] {
		CFG_SRC_MODE   = 2'd0,
		CFG_KEY_COLOR  = 2'd1,
		CFG_KEY_ENABLE = 2'd2
	} pbc_cfg_idx_t;

	typedef enum logic {
		FUNC_PAL_WRITE = 1'b0,
		FUNC_COMPOSE   = 1'b1
	} pbc_func_t;

	typedef enum logic [1:0] {
		OUT_SKIP  = 2'd0,
		OUT_PAL   = 2'd1,
		OUT_BLEND = 2'd2,
		OUT_COPY  = 2'd3
	} pbc_out_kind_t;

endpackage

### design/pixel_blit_compositor.sv
// pixel blit compositor: palette store, alpha blend and color key pipeline
// One item is accepted per clock while the output side keeps up. A compose item
// runs through two stages: the first reads the palette memory (synchronous
// read) and forms the per-channel blend products, the second finishes the
// divide by 255 and loads the output register, from which its result is
// offered. A palette write item updates the memory at its acceptance edge,
// gives no result, and is seen by every later compose item. While a result
// waits in the output register with out_ready low, the whole pipeline holds
// and in_ready drops. Configuration registers are sampled when a compose
// item is accepted.
module pixel_blit_compositor
	import pbc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [7:0]  pal_index,
	input  logic [31:0] src_pixel,
	input  logic [31:0] dst_pixel,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        write_enable,
	output logic [31:0] out_pixel
);

	logic [1:0]  src_mode_q;
	logic [31:0] key_color_q;
	logic        key_enable_q;

	logic [23:0] pal_mem [PALETTE_DEPTH];

	logic        en;
	logic        accept;
	logic        wr_pal;
	logic        rd_pal;
	logic [7:0]  rd_idx;
	logic        wr_in_range;
	logic        rd_in_range;
	logic [7:0]  src_a;
	logic [7:0]  inv_a;
	pbc_out_kind_t kind;
	logic [15:0] prod_s [3];
	logic [15:0] prod_d [3];

	logic          v_s1;
	pbc_out_kind_t kind_s1;
	logic          pal_ok_s1;
	logic [23:0]   pal_rd_s1;
	logic [31:0]   src_s1;
	logic [31:0]   dst_s1;
	logic [15:0]   prod_s_s1 [3];
	logic [15:0]   prod_d_s1 [3];

	logic [7:0]  blend_ch [3];
	logic        we_d;
	logic [31:0] px_d;

	logic        out_valid_q;
	logic        we_q;
	logic [31:0] px_q;

	function automatic logic [7:0] div255(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] x;
		logic [16:0] t;
		x = {1'b0, a} + {1'b0, b};
		t = x + 17'd1 + (x >> 8);
		return t[15:8];
	endfunction

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_mode_q   <= MODE_COPY;
			key_color_q  <= '0;
			key_enable_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SRC_MODE:   src_mode_q   <= cfg_data[1:0];
				CFG_KEY_COLOR:  key_color_q  <= cfg_data;
				CFG_KEY_ENABLE: key_enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;
	assign accept   = in_valid && in_ready;

	assign wr_in_range = {1'b0, pal_index} < 9'(PALETTE_DEPTH);
	assign rd_idx      = src_pixel[7:0];
	assign rd_in_range = {1'b0, rd_idx} < 9'(PALETTE_DEPTH);
	assign wr_pal      = accept && (func == FUNC_PAL_WRITE) && wr_in_range;
	assign rd_pal      = accept && (func == FUNC_COMPOSE);

	// palette memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_pal) begin
			pal_mem[pal_index[PAL_AW-1:0]] <= src_pixel[23:0];
		end
		if (rd_pal && rd_in_range) begin
			pal_rd_s1 <= pal_mem[rd_idx[PAL_AW-1:0]];
		end
	end

	// item decode and blend products
	assign src_a = src_pixel[31:24];
	assign inv_a = CH_MAX - src_a;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			prod_s[c] = 16'(src_pixel[8*c +: 8]) * 16'(src_a);
			prod_d[c] = 16'(dst_pixel[8*c +: 8]) * 16'(inv_a);
		end
	end

	always_comb begin
		unique case (src_mode_q)
			MODE_PALETTE: begin
				if (key_enable_q && ({24'd0, rd_idx} == key_color_q)) kind = OUT_SKIP;
				else kind = OUT_PAL;
			end
			MODE_ALPHA: begin
				if (src_a == 8'd0) kind = OUT_SKIP;
				else if (src_a == CH_MAX) kind = OUT_COPY;
				else kind = OUT_BLEND;
			end
			default: begin
				if (key_enable_q && (src_pixel == key_color_q)) kind = OUT_SKIP;
				else kind = OUT_COPY;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= rd_pal;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_pal) begin
			kind_s1   <= kind;
			pal_ok_s1 <= rd_in_range;
			src_s1    <= src_pixel;
			dst_s1    <= dst_pixel;
			for (int c = 0; c < 3; c++) begin
				prod_s_s1[c] <= prod_s[c];
				prod_d_s1[c] <= prod_d[c];
			end
		end
	end

	// divide by 255 and result select
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			blend_ch[c] = div255(prod_s_s1[c], prod_d_s1[c]);
		end
	end

	always_comb begin
		unique case (kind_s1)
			OUT_SKIP: begin
				we_d = 1'b0;
				px_d = dst_s1;
			end
			OUT_PAL: begin
				we_d = 1'b1;
				px_d = pal_ok_s1 ? (OPAQUE_ALPHA | {8'd0, pal_rd_s1}) : OPAQUE_ALPHA;
			end
			OUT_BLEND: begin
				we_d = 1'b1;
				px_d = {CH_MAX, blend_ch[2], blend_ch[1], blend_ch[0]};
			end
			OUT_COPY: begin
				we_d = 1'b1;
				px_d = src_s1;
			end
			default: begin
				we_d = 1'b1;
				px_d = src_s1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s1) begin
			we_q <= we_d;
			px_q <= px_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign write_enable = we_q;
	assign out_pixel    = px_q;

	a_compose_enters: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (func == FUNC_COMPOSE) |=> v_s1)
		else $error("accepted compose item missing from first stage");

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (func == FUNC_PAL_WRITE) |=> !v_s1)
		else $error("palette write item produced a pipeline entry");

	a_s1_advances: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && en |=> out_valid_q)
		else $error("first stage item lost on the way to the output register");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !en |=> v_s1 && $stable(src_s1) && $stable(kind_s1))
		else $error("first stage changed while output stalled");

endmodule
